// File: hdl/vtm_pkg.sv
package vtm_pkg;

  localparam int SlotsDefault = 16;
  localparam int MaxResults   = 16;
  localparam int FireCntW     = $clog2(MaxResults + 1);

  localparam int IntervalW  = 32;
  localparam int SlotFieldW = 4;
  localparam int OpW        = 2;
  localparam int KindW      = 2;
  localparam int StatusW    = 2;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 8;

  localparam logic [OpW-1:0] OpTick   = 2'd0;
  localparam logic [OpW-1:0] OpStart  = 2'd1;
  localparam logic [OpW-1:0] OpCancel = 2'd2;

  localparam logic [KindW-1:0] KindStart  = 2'd0;
  localparam logic [KindW-1:0] KindCancel = 2'd1;
  localparam logic [KindW-1:0] KindFire   = 2'd2;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StInactive = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic now_inc;
    logic start;
    logic cancel;
    logic scan_first;
    logic chk;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic push_need;
    logic pend_valid;
    logic scan_last;
  } stat_t;

endpackage

// File: hdl/vtm_ctrl.sv
module vtm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [vtm_pkg::OpW-1:0] op_i,
  output logic                in_ready_o,
  input  vtm_pkg::stat_t      stat_i,
  output vtm_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StCancel,
    StScanFirst,
    StScan,
    StFlush
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (op_i)
              vtm_pkg::OpTick:   state_q <= StScanFirst;
              vtm_pkg::OpStart:  state_q <= StStart;
              vtm_pkg::OpCancel: state_q <= StCancel;
              default:           state_q <= StIdle;
            endcase
          end
        end
        StStart, StCancel: begin
          if (stat_i.out_free) state_q <= StIdle;
        end
        StScanFirst: state_q <= StScan;
        StScan: begin
          if (!(stat_i.push_need && !stat_i.out_free) && stat_i.scan_last) begin
            state_q <= StFlush;
          end
        end
        StFlush: begin
          if (!stat_i.pend_valid || stat_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load    = accept;
        cmd_o.now_inc = accept && (op_i == vtm_pkg::OpTick);
      end
      StStart:     cmd_o.start      = stat_i.out_free;
      StCancel:    cmd_o.cancel     = stat_i.out_free;
      StScanFirst: cmd_o.scan_first = 1'b1;
      // hold the slot while a fire waits for the output register
      StScan:      cmd_o.chk        = !(stat_i.push_need && !stat_i.out_free);
      StFlush:     cmd_o.flush      = stat_i.pend_valid && stat_i.out_free;
      default:     cmd_o            = '0;
    endcase
  end

endmodule

// File: hdl/vtm_datapath.sv
module vtm_datapath #(
  parameter int SLOTS = vtm_pkg::SlotsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vtm_pkg::cmd_t                     cmd_i,
  output vtm_pkg::stat_t                    stat_o,
  input  logic [vtm_pkg::IntervalW-1:0]     interval_i,
  input  logic                              repeat_req_i,
  input  logic [vtm_pkg::SlotFieldW-1:0]    cancel_slot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [vtm_pkg::KindW-1:0]         out_kind_o,
  output logic [vtm_pkg::SlotFieldW-1:0]    out_slot_o,
  output logic [vtm_pkg::StatusW-1:0]       out_status_o,
  output logic                              out_last_o
);

  localparam int SlotW = $clog2(SLOTS);
  localparam int TW    = (SlotW > vtm_pkg::SlotFieldW) ? SlotW : vtm_pkg::SlotFieldW;

  function automatic logic [vtm_pkg::SlotFieldW-1:0] to_slot(input logic [SlotW-1:0] idx);
    logic [TW-1:0] e;
    e = TW'(idx);
    return e[vtm_pkg::SlotFieldW-1:0];
  endfunction

  logic [vtm_pkg::IntervalW-1:0] exp_mem [SLOTS];
  logic [vtm_pkg::IntervalW-1:0] per_mem [SLOTS];
  logic [vtm_pkg::IntervalW-1:0] rd_exp_q, rd_per_q;
  logic [vtm_pkg::IntervalW-1:0] now_q;
  logic [vtm_pkg::IntervalW-1:0] ivl_q;
  logic                          rep_q;
  logic [vtm_pkg::SlotFieldW-1:0] tid_q;
  logic [SLOTS-1:0]              active_q, repeat_q;
  logic [SlotW-1:0]              idx_q;
  logic                          pend_valid_q;
  logic [vtm_pkg::SlotFieldW-1:0] pend_slot_q;
  logic [vtm_pkg::FireCntW-1:0]  fire_cnt_q;

  logic                          out_valid_q;
  logic [vtm_pkg::KindW-1:0]     out_kind_q;
  logic [vtm_pkg::SlotFieldW-1:0] out_slot_q;
  logic [vtm_pkg::StatusW-1:0]   out_status_q;
  logic                          out_last_q;

  logic [SlotW-1:0]  free_idx;
  logic              full;
  logic [TW-1:0]     tid_ext;
  logic              tid_hit;
  logic              hit, room, scan_last;
  logic              rd_en;
  logic [SlotW-1:0]  rd_addr;
  logic              exp_we;
  logic [SlotW-1:0]  exp_waddr;
  logic [vtm_pkg::IntervalW-1:0] exp_wdata;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = SlotW'(i);
        full     = 1'b0;
      end
    end
  end

  assign tid_ext   = TW'(tid_q);
  assign tid_hit   = (32'(tid_q) < SLOTS) && active_q[tid_ext[SlotW-1:0]];
  assign hit       = active_q[idx_q] && (rd_exp_q == now_q);
  assign room      = fire_cnt_q < vtm_pkg::FireCntW'(vtm_pkg::MaxResults);
  assign scan_last = (32'(idx_q) == SLOTS - 1);

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.push_need  = hit && room && pend_valid_q;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.scan_last  = scan_last;

  assign rd_en   = cmd_i.scan_first || (cmd_i.chk && !scan_last);
  assign rd_addr = cmd_i.scan_first ? '0 : idx_q + SlotW'(1);

  always_comb begin
    exp_we    = 1'b0;
    exp_waddr = free_idx;
    exp_wdata = now_q + ivl_q;
    if (cmd_i.start && !full) begin
      exp_we = 1'b1;
    end else if (cmd_i.chk && hit && repeat_q[idx_q]) begin
      // re-arm one period after the due time
      exp_we    = 1'b1;
      exp_waddr = idx_q;
      exp_wdata = rd_exp_q + rd_per_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    if (cmd_i.start && !full) per_mem[free_idx] <= ivl_q;
    if (rd_en) begin
      rd_exp_q <= exp_mem[rd_addr];
      rd_per_q <= per_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ivl_q <= (interval_i == '0) ? vtm_pkg::IntervalW'(1) : interval_i;
      rep_q <= repeat_req_i;
      tid_q <= cancel_slot_i;
    end
    if (cmd_i.chk && hit && room) pend_slot_q <= to_slot(idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      active_q     <= '0;
      repeat_q     <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      fire_cnt_q   <= '0;
    end else begin
      if (cmd_i.now_inc) now_q <= now_q + vtm_pkg::IntervalW'(1);
      if (cmd_i.start && !full) begin
        active_q[free_idx] <= 1'b1;
        repeat_q[free_idx] <= rep_q;
      end
      if (cmd_i.cancel && tid_hit) active_q[tid_ext[SlotW-1:0]] <= 1'b0;
      if (cmd_i.scan_first) begin
        idx_q        <= '0;
        pend_valid_q <= 1'b0;
        fire_cnt_q   <= '0;
      end
      if (cmd_i.chk) begin
        if (hit && !repeat_q[idx_q]) active_q[idx_q] <= 1'b0;
        if (hit && room) begin
          pend_valid_q <= 1'b1;
          fire_cnt_q   <= fire_cnt_q + vtm_pkg::FireCntW'(1);
        end
        if (!scan_last) idx_q <= idx_q + SlotW'(1);
      end
      if (cmd_i.flush) pend_valid_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.start || cmd_i.cancel || cmd_i.flush ||
                 (cmd_i.chk && stat_o.push_need)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      out_kind_q   <= vtm_pkg::KindStart;
      out_slot_q   <= full ? '0 : to_slot(free_idx);
      out_status_q <= full ? vtm_pkg::StFull : vtm_pkg::StOk;
      out_last_q   <= 1'b1;
    end else if (cmd_i.cancel) begin
      out_kind_q   <= vtm_pkg::KindCancel;
      out_slot_q   <= tid_q;
      out_status_q <= tid_hit ? vtm_pkg::StOk : vtm_pkg::StInactive;
      out_last_q   <= 1'b1;
    end else if (cmd_i.flush || (cmd_i.chk && stat_o.push_need)) begin
      // a held fire goes out once the next one is known, or at scan end
      out_kind_q   <= vtm_pkg::KindFire;
      out_slot_q   <= pend_slot_q;
      out_status_q <= vtm_pkg::StOk;
      out_last_q   <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_slot_o   = out_slot_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// File: hdl/virtual_timer_multiplexer.sv
// Virtual timer multiplexer: SLOTS software timers share one microsecond count.
// Slave stream: tuser carries the operation (tick, start, cancel); tdata carries
// interval, repeat_req and cancel_slot. Master stream: tuser carries the event kind,
// tdata the slot and status, tlast marks the final result of an input item.
// One item is worked at a time; s_axis_tready_o is high only while idle.
// Start and cancel: the reply is loaded into the output register from the start
// or cancel state once that register is free, and the block is ready again in the
// cycle after that load. Tick: the count advances, then the expiry and period
// memories are scanned one slot per cycle through their registered read port,
// except in every cycle in which a fire waits for the output register. Each fire
// result is held back until the next one is known, so that tlast can be set on
// the final one; at most MaxResults fires are reported per tick, due periodic
// slots re-arm and due one-shot slots are freed. Reset clears the count and all
// active flags; no timers run afterwards. When the receiver stalls, the output
// register holds its item and the scan waits on the next fire that needs that
// register.
module virtual_timer_multiplexer #(
  parameter int SLOTS = vtm_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] interval, [32] repeat_req, [36:33] cancel_slot, [39:37] zero
  input  logic [vtm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] operation
  input  logic [vtm_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [3:0] slot, [5:4] status, [7:6] zero
  output logic [vtm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [1:0] event_kind
  output logic [vtm_pkg::KindW-1:0]     m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  vtm_pkg::cmd_t  cmd;
  vtm_pkg::stat_t stat;
  logic [vtm_pkg::SlotFieldW-1:0] out_slot;
  logic [vtm_pkg::StatusW-1:0]    out_status;

  vtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .op_i       (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vtm_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .interval_i    (s_axis_tdata_i[31:0]),
    .repeat_req_i  (s_axis_tdata_i[32]),
    .cancel_slot_i (s_axis_tdata_i[36:33]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_kind_o    (m_axis_tuser_o),
    .out_slot_o    (out_slot),
    .out_status_o  (out_status),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_status, out_slot};

endmodule

// File: hdl/vtm_checker.sv
module vtm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [vtm_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic [vtm_pkg::OpW-1:0]       s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [vtm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [vtm_pkg::KindW-1:0]     m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // start and cancel results always carry tlast
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != vtm_pkg::KindFire) |-> m_axis_tlast_o)
    else $error("reply without tlast");

  a_full_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[5:4] == vtm_pkg::StFull) |->
      (m_axis_tuser_o == vtm_pkg::KindStart) && (m_axis_tdata_o[3:0] == 4'd0))
    else $error("table full status on wrong result");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == vtm_pkg::KindFire) |->
      (m_axis_tdata_o[5:4] == vtm_pkg::StOk))
    else $error("fire result with bad status");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o &&
      (s_axis_tuser_i == vtm_pkg::OpStart || s_axis_tuser_i == vtm_pkg::OpCancel)
      |=> !s_axis_tready_o)
    else $error("ready while a start or cancel is in work");

endmodule

bind virtual_timer_multiplexer vtm_checker u_vtm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// File: bench/virtual_timer_multiplexer_tb.sv
`timescale 1ns / 1ps

module virtual_timer_multiplexer_tb;

  localparam int NumSlots = vtm_pkg::SlotsDefault;
  localparam logic [vtm_pkg::OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [vtm_pkg::KindW-1:0]      kind;
    logic [vtm_pkg::SlotFieldW-1:0] slot;
    logic [vtm_pkg::StatusW-1:0]    status;
    logic                           last;
  } timer_event_t;

  // Tracks the timer table and holds the events the block still owes.
  class timer_table_tracker;
    logic [vtm_pkg::IntervalW-1:0] now_us;
    logic [vtm_pkg::IntervalW-1:0] expiry_us [NumSlots];
    logic [vtm_pkg::IntervalW-1:0] period_us [NumSlots];
    bit                            periodic  [NumSlots];
    bit                            armed     [NumSlots];
    timer_event_t                  due_events[$];
    int unsigned                   mismatches;

    function new();
      now_us = '0;
      mismatches = 0;
      for (int i = 0; i < NumSlots; i++) begin
        expiry_us[i] = '0;
        period_us[i] = '0;
        periodic[i]  = 1'b0;
        armed[i]     = 1'b0;
      end
    endfunction

    function int unsigned armed_count();
      int unsigned n;
      n = 0;
      for (int i = 0; i < NumSlots; i++) n += armed[i];
      return n;
    endfunction

    function void note_item(logic [vtm_pkg::OpW-1:0] op,
                            logic [vtm_pkg::IntervalW-1:0] ivl, logic rep,
                            logic [vtm_pkg::SlotFieldW-1:0] tid);
      timer_event_t ev;
      bit           held;
      int           n;
      logic [vtm_pkg::IntervalW-1:0] len;
      held = 1'b0;
      n = 0;
      len = (ivl == '0) ? 32'd1 : ivl;
      ev = '0;
      case (op)
        vtm_pkg::OpStart: begin
          ev.kind   = vtm_pkg::KindStart;
          ev.slot   = '0;
          ev.status = vtm_pkg::StFull;
          ev.last   = 1'b1;
          for (int i = 0; i < NumSlots; i++) begin
            if (!armed[i]) begin
              armed[i]     = 1'b1;
              periodic[i]  = rep;
              period_us[i] = len;
              expiry_us[i] = now_us + len;
              ev.slot      = i[vtm_pkg::SlotFieldW-1:0];
              ev.status    = vtm_pkg::StOk;
              break;
            end
          end
          due_events.push_back(ev);
        end
        vtm_pkg::OpCancel: begin
          ev.kind = vtm_pkg::KindCancel;
          ev.slot = tid;
          ev.last = 1'b1;
          if (int'(tid) < NumSlots && armed[tid]) begin
            armed[tid] = 1'b0;
            ev.status  = vtm_pkg::StOk;
          end else begin
            ev.status = vtm_pkg::StInactive;
          end
          due_events.push_back(ev);
        end
        vtm_pkg::OpTick: begin
          now_us = now_us + 32'd1;
          for (int i = 0; i < NumSlots; i++) begin
            if (armed[i] && expiry_us[i] == now_us) begin
              // hold each fire back until the next one so the final one can carry last
              if (n < vtm_pkg::MaxResults) begin
                if (held) due_events.push_back(ev);
                ev.kind   = vtm_pkg::KindFire;
                ev.slot   = i[vtm_pkg::SlotFieldW-1:0];
                ev.status = vtm_pkg::StOk;
                ev.last   = 1'b0;
                held = 1'b1;
                n++;
              end
              if (periodic[i]) expiry_us[i] = expiry_us[i] + period_us[i];
              else armed[i] = 1'b0;
            end
          end
          if (held) begin
            ev.last = 1'b1;
            due_events.push_back(ev);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_event(timer_event_t got);
      timer_event_t exp_ev;
      if (due_events.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d status %0d last %0d",
               got.kind, got.slot, got.status, got.last);
        mismatches++;
        return;
      end
      exp_ev = due_events.pop_front();
      if (got.kind != exp_ev.kind) begin
        $error("event_kind: expected %0d, got %0d", exp_ev.kind, got.kind);
        mismatches++;
      end
      if (got.slot != exp_ev.slot) begin
        $error("slot: expected %0d, got %0d", exp_ev.slot, got.slot);
        mismatches++;
      end
      if (got.status != exp_ev.status) begin
        $error("status: expected %0d, got %0d", exp_ev.status, got.status);
        mismatches++;
      end
      if (got.last != exp_ev.last) begin
        $error("last: expected %0d, got %0d", exp_ev.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni = 1'b0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [vtm_pkg::InDataW-1:0]         s_tdata = '0;
  logic [vtm_pkg::OpW-1:0]             s_tuser = vtm_pkg::OpTick;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [vtm_pkg::OutDataW-1:0]        m_tdata;
  logic [vtm_pkg::KindW-1:0]           m_tuser;
  logic                                m_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  timer_table_tracker timers = new();

  virtual_timer_multiplexer #(.SLOTS(NumSlots)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: pick tready at the rising edge, look at the settled handshake at
  // the falling edge; it is taken at the next rising edge.
  initial begin
    timer_event_t got;
    forever begin
      @(posedge clk_i);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      @(negedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        got.kind   = m_tuser;
        got.slot   = m_tdata[vtm_pkg::SlotFieldW-1:0];
        got.status = m_tdata[vtm_pkg::SlotFieldW +: vtm_pkg::StatusW];
        got.last   = m_tlast;
        timers.check_event(got);
      end
    end
  end

  task automatic send_item(input logic [vtm_pkg::OpW-1:0] op,
                           input logic [vtm_pkg::IntervalW-1:0] ivl,
                           input logic rep, input logic [vtm_pkg::SlotFieldW-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, tid, rep, ivl};
    // tready is settled mid-cycle; the item is taken at the following edge
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
    timers.note_item(op, ivl, rep, tid);
  endtask

  task automatic send_random_item();
    int unsigned r;
    int unsigned n_armed;
    int unsigned cancel_pct;
    logic [vtm_pkg::IntervalW-1:0]  ivl;
    logic [vtm_pkg::SlotFieldW-1:0] tid;
    r = $urandom_range(99);
    n_armed = timers.armed_count();
    // drain a crowded table faster so starts keep finding free slots
    cancel_pct = (n_armed > 10) ? 40 : 15;
    if ($urandom_range(99) < 80) ivl = $urandom_range(12);
    else if ($urandom_range(99) < 50) ivl = $urandom_range(60, 13);
    else ivl = $urandom;
    tid = vtm_pkg::SlotFieldW'($urandom_range(15));
    if (n_armed != 0 && $urandom_range(99) < 70) begin
      do tid = vtm_pkg::SlotFieldW'($urandom_range(NumSlots - 1)); while (!timers.armed[tid]);
    end
    if (r < 3) begin
      send_item(OpUnused, $urandom, 1'($urandom_range(1)),
                vtm_pkg::SlotFieldW'($urandom_range(15)));
    end else if (r < 3 + cancel_pct) begin
      send_item(vtm_pkg::OpCancel, $urandom, 1'($urandom_range(1)), tid);
    end else if (r < 33 + cancel_pct) begin
      send_item(vtm_pkg::OpStart, ivl, 1'($urandom_range(1)), tid);
    end else begin
      send_item(vtm_pkg::OpTick, ivl, 1'($urandom_range(1)), tid);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cancel of an idle slot, empty tick, unused code
    send_item(vtm_pkg::OpCancel, '0, 1'b0, 4'd0);
    send_item(vtm_pkg::OpTick, '0, 1'b0, 4'd0);
    send_item(OpUnused, 32'hFFFF_FFFF, 1'b1, 4'hF);
    // fill the table with timers due on the same tick; zero interval acts as one
    send_item(vtm_pkg::OpStart, '0, 1'b0, 4'd0);
    for (int i = 1; i < NumSlots; i++) send_item(vtm_pkg::OpStart, 32'd1, 1'b1, 4'd0);
    send_item(vtm_pkg::OpStart, 32'hFFFF_FFFF, 1'b1, 4'hF);
    // every slot fires at once; slot 0 is freed, the rest re-arm
    send_item(vtm_pkg::OpTick, 32'hFFFF_FFFF, 1'b1, 4'hF);
    send_item(vtm_pkg::OpCancel, 32'hFFFF_FFFF, 1'b1, 4'hF);
    send_item(vtm_pkg::OpStart, 32'hFFFF_FFFF, 1'b1, 4'd0);
    send_item(vtm_pkg::OpTick, '0, 1'b0, 4'd0);
    send_item(vtm_pkg::OpCancel, '0, 1'b0, 4'hF);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (84) send_random_item();
    end
    s_tvalid <= 1'b0;

    while (timers.due_events.size() != 0) @(posedge clk_i);
    repeat (NumSlots + 40) @(posedge clk_i);
    if (timers.mismatches == 0 && timers.due_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
